@@ src/deq_pkg.sv @@
package deq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned FuncW = 3;
  localparam int unsigned StatW = 2;

  typedef enum logic [FuncW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // qualified shift commands broadcast to every cell
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } cell_cmd_t;

endpackage

@@ src/deq_cell.sv @@
module deq_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  deq_pkg::cell_cmd_t               cmd_i,
  input  logic signed [deq_pkg::DataW-1:0] push_value_i,
  input  logic                             left_valid_i,
  input  logic signed [deq_pkg::DataW-1:0] left_data_i,
  input  logic                             right_valid_i,
  input  logic signed [deq_pkg::DataW-1:0] right_data_i,
  output logic                             valid_o,
  output logic signed [deq_pkg::DataW-1:0] data_o,
  output logic                             tail_o
);

  logic                             valid_q, valid_d;
  logic signed [deq_pkg::DataW-1:0] data_q, data_d;

  assign tail_o = valid_q && !right_valid_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (cmd_i.push_front) begin
      valid_d = left_valid_i;
      data_d  = left_data_i;
    end else if (cmd_i.push_back) begin
      if (!valid_q && left_valid_i) begin
        valid_d = 1'b1;
        data_d  = push_value_i;
      end
    end else if (cmd_i.pop_front) begin
      valid_d = right_valid_i;
      data_d  = right_data_i;
    end else if (cmd_i.pop_back) begin
      if (tail_o) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ src/double_ended_queue_unit.sv @@
// Result: an accepted request's result lands in the output register in the next cycle.
// Throughput: one request per cycle; the only limit is the output register being
// drained by the downstream side.
// Reset: all cell valid bits, the entry count and the output valid clear at once;
// stored data needs no clearing.
module double_ended_queue_unit #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned CntW = $clog2(CAPACITY + 1),
  localparam int unsigned InW  = ((deq_pkg::FuncW + deq_pkg::DataW + 7) / 8) * 8,
  localparam int unsigned OutRawW = deq_pkg::StatW + deq_pkg::DataW + CntW,
  localparam int unsigned OutW = ((OutRawW + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // func [2:0], push_value [34:3]
  input  logic [InW-1:0]     s_axis_tdata_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // status [1:0], data_out [33:2], length_after [CntW+33:34]
  output logic [OutW-1:0]    m_axis_tdata_o
);

  logic                             accept;
  deq_pkg::op_e                     op;
  logic signed [deq_pkg::DataW-1:0] push_value;
  logic                             full, empty;
  deq_pkg::cell_cmd_t               cmd;
  deq_pkg::status_e                 status;
  logic signed [deq_pkg::DataW-1:0] data_out;

  logic [CntW-1:0]                  cnt_q, cnt_d;
  logic                             out_valid_q;
  logic [OutRawW-1:0]               out_data_q;

  logic [CAPACITY-1:0]              cell_valid;
  logic [CAPACITY-1:0]              cell_tail;
  logic signed [deq_pkg::DataW-1:0] cell_data [CAPACITY];
  logic signed [deq_pkg::DataW-1:0] back_data;

  assign op         = deq_pkg::op_e'(s_axis_tdata_i[deq_pkg::FuncW-1:0]);
  assign push_value = s_axis_tdata_i[deq_pkg::FuncW +: deq_pkg::DataW];
  assign full       = (cnt_q == CntW'(CAPACITY));
  assign empty      = (cnt_q == '0);

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    back_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_tail[i]) begin
        back_data = back_data | cell_data[i];
      end
    end
  end

  always_comb begin
    cmd      = '0;
    status   = deq_pkg::ST_OK;
    data_out = '0;
    cnt_d    = cnt_q;
    case (op)
      deq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status = deq_pkg::ST_FULL;
        end else begin
          cmd.push_front = accept;
          cnt_d          = cnt_q + 1'b1;
        end
      end
      deq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status = deq_pkg::ST_FULL;
        end else begin
          cmd.push_back = accept;
          cnt_d         = cnt_q + 1'b1;
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status = deq_pkg::ST_EMPTY;
        end else begin
          cmd.pop_front = accept;
          data_out      = cell_data[0];
          cnt_d         = cnt_q - 1'b1;
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (empty) begin
          status = deq_pkg::ST_EMPTY;
        end else begin
          cmd.pop_back = accept;
          data_out     = back_data;
          cnt_d        = cnt_q - 1'b1;
        end
      end
      deq_pkg::OP_PEEK_FRONT: begin
        if (empty) begin
          status = deq_pkg::ST_EMPTY;
        end else begin
          data_out = cell_data[0];
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                             left_valid, right_valid;
    logic signed [deq_pkg::DataW-1:0] left_data, right_data;

    if (g == 0) begin : g_head
      assign left_valid = 1'b1;
      assign left_data  = push_value;
    end else begin : g_mid
      assign left_valid = cell_valid[g-1];
      assign left_data  = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_end
      assign right_valid = 1'b0;
      assign right_data  = '0;
    end else begin : g_inner
      assign right_valid = cell_valid[g+1];
      assign right_data  = cell_data[g+1];
    end

    deq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .push_value_i  (push_value),
      .left_valid_i  (left_valid),
      .left_data_i   (left_data),
      .right_valid_i (right_valid),
      .right_data_i  (right_data),
      .valid_o       (cell_valid[g]),
      .data_o        (cell_data[g]),
      .tail_o        (cell_tail[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q <= cnt_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {cnt_d, data_out, status};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutW'(out_data_q);

  // occupied cells always form a contiguous run from the front
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("gap in occupied cells");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(cnt_q))
    else $error("entry count disagrees with occupied cells");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[deq_pkg::StatW-1:0] == deq_pkg::ST_FULL) |->
    (out_data_q[OutRawW-1 -: CntW] == CntW'(CAPACITY)))
    else $error("full reported below capacity");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned FuncW  = deq_pkg::FuncW;
  localparam int unsigned DataW  = deq_pkg::DataW;
  localparam int unsigned StatW  = deq_pkg::StatW;
  localparam int unsigned Depth  = 64;
  localparam int unsigned LenW   = $clog2(Depth + 1);
  localparam int unsigned ReqW   = ((FuncW + DataW + 7) / 8) * 8;
  localparam int unsigned RespW  = ((StatW + DataW + LenW + 7) / 8) * 8;
  localparam int unsigned NumReq = 1450;

  typedef struct {
    logic [FuncW-1:0] func;
    logic [DataW-1:0] value;
    bit               wait_idle;
  } deq_req_t;

  typedef struct {
    deq_pkg::status_e status;
    logic [DataW-1:0] data;
    logic [LenW-1:0]  len;
  } deq_resp_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  // func [2:0], push_value [34:3]
  logic [ReqW-1:0]  s_axis_tdata_i;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i;
  // status [1:0], data_out [33:2], length_after [40:34]
  logic [RespW-1:0] m_axis_tdata_o;

  double_ended_queue_unit #(
    .CAPACITY(Depth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // shadow deque
  logic [DataW-1:0] ring_mem [Depth];
  int unsigned      head_idx;
  int unsigned      tail_idx;
  int unsigned      fill_level;

  deq_req_t  req_pending [$];
  deq_resp_t resp_due [$];
  int unsigned mismatches;
  int unsigned resp_seen;
  bit          req_fire;

  function automatic deq_resp_t deque_apply(logic [FuncW-1:0] func,
                                            logic [DataW-1:0] value);
    deq_resp_t r;
    r.status = deq_pkg::ST_OK;
    r.data   = '0;
    case (func)
      deq_pkg::OP_PUSH_FRONT: begin
        if (fill_level >= Depth) begin
          r.status = deq_pkg::ST_FULL;
        end else begin
          head_idx = (head_idx + Depth - 1) % Depth;
          ring_mem[head_idx] = value;
          fill_level++;
        end
      end
      deq_pkg::OP_PUSH_BACK: begin
        if (fill_level >= Depth) begin
          r.status = deq_pkg::ST_FULL;
        end else begin
          ring_mem[tail_idx] = value;
          tail_idx = (tail_idx + 1) % Depth;
          fill_level++;
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (fill_level == 0) begin
          r.status = deq_pkg::ST_EMPTY;
        end else begin
          r.data = ring_mem[head_idx];
          head_idx = (head_idx + 1) % Depth;
          fill_level--;
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (fill_level == 0) begin
          r.status = deq_pkg::ST_EMPTY;
        end else begin
          tail_idx = (tail_idx + Depth - 1) % Depth;
          r.data = ring_mem[tail_idx];
          fill_level--;
        end
      end
      deq_pkg::OP_PEEK_FRONT: begin
        if (fill_level == 0) begin
          r.status = deq_pkg::ST_EMPTY;
        end else begin
          r.data = ring_mem[head_idx];
        end
      end
      default: ;
    endcase
    r.len = fill_level[LenW-1:0];
    return r;
  endfunction

  task automatic add_req(logic [FuncW-1:0] func, logic [DataW-1:0] value, bit wait_idle);
    deq_req_t q;
    q.func      = func;
    q.value     = value;
    q.wait_idle = wait_idle;
    req_pending.push_back(q);
  endtask

  function automatic logic [DataW-1:0] pick_value();
    logic [DataW-1:0] v;
    v = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: v = 32'h0000_0000;
        1: v = 32'h8000_0000;
        2: v = 32'h7fff_ffff;
        default: v = 32'hffff_ffff;
      endcase
    end
    return v;
  endfunction

  function automatic logic [FuncW-1:0] pick_func(int unsigned push_pct, int unsigned pop_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      return $urandom_range(0, 1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
    end else if (r < push_pct + pop_pct) begin
      case ($urandom_range(0, 4))
        0, 1: return deq_pkg::OP_POP_FRONT;
        2, 3: return deq_pkg::OP_POP_BACK;
        default: return deq_pkg::OP_PEEK_FRONT;
      endcase
    end
    return 3'($urandom_range(5, 7));
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  // checker: compare each taken result, then predict each taken request
  always @(posedge clk_i) begin
    deq_resp_t want;
    deq_resp_t got;
    req_fire <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      resp_seen++;
      got.status = deq_pkg::status_e'(m_axis_tdata_o[1:0]);
      got.data   = m_axis_tdata_o[33:2];
      got.len    = m_axis_tdata_o[34 +: LenW];
      if (resp_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: status %0d data %h len %0d",
                   got.status, got.data, got.len);
        end
      end else begin
        want = resp_due.pop_front();
        if (got.status !== want.status || got.data !== want.data || got.len !== want.len) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp status %0d data %h len %0d, got status %0d data %h len %0d",
                     want.status, want.data, want.len, got.status, got.data, got.len);
          end
        end
      end
    end
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      resp_due.push_back(deque_apply(s_axis_tdata_i[FuncW-1:0],
                                     s_axis_tdata_i[FuncW +: DataW]));
    end
  end

  // request driver: bursts and gaps, valid held until taken
  int unsigned burst_left;
  int unsigned gap_left;

  always @(negedge clk_i) begin
    logic            nxt_valid;
    logic [ReqW-1:0] nxt_data;
    nxt_valid = s_axis_tvalid_i;
    nxt_data  = s_axis_tdata_i;
    if (rst_ni) begin
      if (req_fire) begin
        void'(req_pending.pop_front());
      end
      if (!(s_axis_tvalid_i && !req_fire)) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_pending.size() > 0 &&
                     (!req_pending[0].wait_idle || resp_due.size() == 0)) begin
          nxt_valid = 1'b1;
          nxt_data  = '0;
          nxt_data[FuncW-1:0]     = req_pending[0].func;
          nxt_data[FuncW +: DataW] = req_pending[0].value;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
    s_axis_tvalid_i <= nxt_valid;
    s_axis_tdata_i  <= nxt_data;
  end

  // result receiver: own stall pattern plus two long hold-offs
  int unsigned hold_left;
  int unsigned holds_done;
  int unsigned pat_mode;
  int unsigned pat_left;

  always @(negedge clk_i) begin
    logic nxt_ready;
    nxt_ready = 1'b0;
    if (rst_ni) begin
      if (hold_left == 0 && ((holds_done == 0 && resp_seen >= 150) ||
                             (holds_done == 1 && resp_seen >= 900))) begin
        hold_left = 300;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else begin
        if (pat_left == 0) begin
          pat_mode = $urandom_range(0, 3);
          pat_left = $urandom_range(10, 80);
        end
        pat_left--;
        case (pat_mode)
          0: nxt_ready = 1'b1;
          1: nxt_ready = 1'($urandom_range(0, 1));
          2: nxt_ready = ($urandom_range(0, 3) == 0);
          default: nxt_ready = pat_left[0];
        endcase
      end
    end
    m_axis_tready_i <= nxt_ready;
  end

  initial begin
    int unsigned mode;
    int unsigned seg;
    int unsigned push_pct;
    int unsigned pop_pct;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    req_fire        = 1'b0;
    head_idx        = 0;
    tail_idx        = 0;
    fill_level      = 0;
    mismatches      = 0;
    resp_seen       = 0;
    burst_left      = 0;
    gap_left        = 0;
    hold_left       = 0;
    holds_done      = 0;
    pat_left        = 0;
    pat_mode        = 0;
    for (int i = 0; i < Depth; i++) ring_mem[i] = '0;

    // directed: empty, unused codes, extreme values, both ends
    add_req(deq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0);
    add_req(deq_pkg::OP_POP_BACK,   32'hffff_ffff, 1'b0);
    add_req(deq_pkg::OP_PEEK_FRONT, 32'h0000_0000, 1'b0);
    add_req(3'd5,                   32'hffff_ffff, 1'b0);
    add_req(3'd6,                   32'h0000_0000, 1'b0);
    add_req(3'd7,                   32'hffff_ffff, 1'b0);
    add_req(deq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 1'b0);
    add_req(deq_pkg::OP_PUSH_BACK,  32'h7fff_ffff, 1'b0);
    add_req(deq_pkg::OP_PUSH_FRONT, 32'hffff_ffff, 1'b0);
    add_req(deq_pkg::OP_PUSH_BACK,  32'h0000_0000, 1'b0);
    add_req(3'd7,                   32'h1234_5678, 1'b0);
    add_req(deq_pkg::OP_PEEK_FRONT, 32'hffff_ffff, 1'b0);
    add_req(deq_pkg::OP_POP_BACK,   32'h0000_0000, 1'b0);
    add_req(deq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0);
    add_req(deq_pkg::OP_PEEK_FRONT, 32'h0000_0000, 1'b0);
    add_req(deq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0);
    add_req(deq_pkg::OP_POP_BACK,   32'h0000_0000, 1'b0);
    add_req(deq_pkg::OP_POP_BACK,   32'h0000_0000, 1'b0);
    add_req(deq_pkg::OP_PUSH_BACK,  32'h1234_5678, 1'b0);
    add_req(deq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0);

    // random: fill-heavy, drain-heavy and mixed runs so full and empty recur
    while (req_pending.size() < NumReq) begin
      mode = $urandom_range(0, 2);
      seg  = $urandom_range(40, 200);
      case (mode)
        0:       begin push_pct = 75; pop_pct = 22; end
        1:       begin push_pct = 22; pop_pct = 75; end
        default: begin push_pct = 45; pop_pct = 50; end
      endcase
      for (int i = 0; i < seg && req_pending.size() < NumReq; i++) begin
        add_req(pick_func(push_pct, pop_pct), pick_value(),
                i == 0 && $urandom_range(0, 3) == 0);
      end
    end
    req_pending[25].wait_idle = 1'b1;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (req_pending.size() > 0 || resp_due.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && resp_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
